>>> sv/lfra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the lowest free room allocator.
// No dependencies; every other file refers to this package by scoped names.
package lfra_pkg;

    // Widths of the fixed port fields.
    localparam int CUST_FIELD_W = 10;
    localparam int ROOM_FIELD_W = 9;

    // Rooms per group in the two-level lowest-free search.
    localparam int GROUP_W  = 16;
    localparam int GROUP_LW = 4;

    typedef enum logic {
        REQ_ARRIVE = 1'b0,
        REQ_DEPART = 1'b1
    } req_kind_t;

    // Update command from the event stage to the room map.
    typedef struct packed {
        logic take;   // occupy the lowest free room
        logic give;   // free the room on give_room
    } map_cmd_t;

endpackage

>>> sv/lfra_room_map.sv
`timescale 1ns / 1ps
// Room occupancy bitmap with a two-level lowest-free search.
// Depends on lfra_pkg for the map command type and group sizes.
module lfra_room_map #(
    parameter int ROOMS = 256,
    parameter int RW    = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lfra_pkg::map_cmd_t cmd,
    input  logic [RW-1:0]     give_room,
    output logic [RW-1:0]     lowest
);

    localparam int IW  = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int NG  = (ROOMS + lfra_pkg::GROUP_W - 1) / lfra_pkg::GROUP_W;
    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD = NG * lfra_pkg::GROUP_W;
    localparam int SW  = GW + lfra_pkg::GROUP_LW + 1;

    logic [ROOMS-1:0]              free_reg;
    logic [ROOMS-1:0]              free_next;
    logic [PAD-1:0]                free_pad;
    logic [NG-1:0]                 grp_any;
    logic [GW-1:0]                 grp_sel;
    logic [lfra_pkg::GROUP_W-1:0]  grp_bits;
    logic [lfra_pkg::GROUP_LW-1:0] bit_sel;
    logic [SW-1:0]                 found;
    logic [RW-1:0]                 take_idx;
    logic [RW-1:0]                 give_idx;

    assign free_pad = {{(PAD - ROOMS){1'b0}}, free_reg};

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any[g] = |free_pad[g*lfra_pkg::GROUP_W +: lfra_pkg::GROUP_W];
        end
    end

    // Scan from the top down so the lowest hit is the one that remains.
    always_comb
    begin
        grp_sel = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                grp_sel = GW'(g);
            end
        end
    end

    assign grp_bits = free_pad[grp_sel*lfra_pkg::GROUP_W +: lfra_pkg::GROUP_W];

    always_comb
    begin
        bit_sel = '0;
        for (int b = lfra_pkg::GROUP_W - 1; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                bit_sel = lfra_pkg::GROUP_LW'(b);
            end
        end
    end

    assign found  = {1'b0, grp_sel, bit_sel} + SW'(1);
    assign lowest = (|grp_any) ? RW'(found) : '0;

    assign take_idx = lowest - RW'(1);
    assign give_idx = give_room - RW'(1);

    always_comb
    begin
        free_next = free_reg;
        if (cmd.take && (lowest != '0))
        begin
            free_next[take_idx[IW-1:0]] = 1'b0;
        end
        if (cmd.give && (give_room != '0))
        begin
            free_next[give_idx[IW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            free_reg <= free_next;
        end
    end

endmodule

>>> sv/lfra_entry_store.sv
`timescale 1ns / 1ps
// Per-customer room table with registered read and write-to-read forwarding.
// Depends on lfra_pkg for the customer field width.
module lfra_entry_store #(
    parameter int CUSTOMERS = 1024,
    parameter int RW        = 9
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [lfra_pkg::CUST_FIELD_W-1:0] rd_cust,
    input  logic                              wr_en,
    input  logic [RW-1:0]                     wr_data,
    output logic [RW-1:0]                     rd_data
);

    localparam int AW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int CW = lfra_pkg::CUST_FIELD_W;

    logic [RW-1:0] mem [CUSTOMERS];
    logic [AW-1:0] addr;
    logic [AW-1:0] addr_reg;
    logic [RW-1:0] mem_rd_reg;
    logic [RW-1:0] fwd_data_reg;
    logic          fwd_hit_reg;

    // Customer numbers wrap modulo the table depth.
    generate
        if (CUSTOMERS >= (1 << CW))
        begin : g_no_wrap
            assign addr = AW'(rd_cust);
        end
        else if ((CUSTOMERS & (CUSTOMERS - 1)) == 0)
        begin : g_mask
            assign addr = rd_cust[AW-1:0];
        end
        else
        begin : g_recip
            localparam int RECIP = (1 << 20) / CUSTOMERS;
            logic [29:0]   prod;
            logic [CW-1:0] quot;
            logic [19:0]   back;
            logic [CW:0]   rem;
            logic [CW:0]   rem_fix;
            // The quotient estimate is exact or one short, so one
            // compare and subtract finishes the remainder.
            assign prod    = 30'(rd_cust) * 30'(RECIP);
            assign quot    = prod[29:20];
            assign back    = 20'(quot) * 20'(CUSTOMERS);
            assign rem     = {1'b0, rd_cust} - back[CW:0];
            assign rem_fix = (rem >= (CW+1)'(CUSTOMERS)) ? rem - (CW+1)'(CUSTOMERS) : rem;
            assign addr    = rem_fix[AW-1:0];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[addr];
        end
    end

    // A read on the same edge as a write to the same entry sees old data,
    // so the written value is carried alongside.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_reg     <= addr;
            fwd_hit_reg  <= wr_en && (addr_reg == addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_rd_reg;

endmodule

>>> sv/lowest_free_room_allocator.sv
`timescale 1ns / 1ps
// A transaction accepted at one edge gives its result (done high) through the registered
// read of the customer table and then the result register.
// Throughput: one transaction per cycle; busy stays low and results cannot be stalled.
// Reset: all rooms free and the peak at zero; customer table contents are undefined.
// Depends on lfra_pkg, lfra_room_map and lfra_entry_store.
module lowest_free_room_allocator #(
    parameter int ROOMS     = 256,
    parameter int CUSTOMERS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [lfra_pkg::CUST_FIELD_W-1:0] customer,
    output logic                              done,
    output logic [lfra_pkg::ROOM_FIELD_W-1:0] room,
    output logic [lfra_pkg::ROOM_FIELD_W-1:0] peak_room,
    output logic                              no_room
);

    localparam int RW = $clog2(ROOMS + 1);
    localparam int FW = lfra_pkg::ROOM_FIELD_W;

    logic                accept;
    logic                v_reg;
    lfra_pkg::req_kind_t kind_reg;
    lfra_pkg::map_cmd_t  map_cmd;
    logic [RW-1:0]       lowest;
    logic [RW-1:0]       entry;
    logic [RW-1:0]       room_next;
    logic                fail_next;
    logic [RW-1:0]       wr_data;
    logic [RW-1:0]       peak_reg;
    logic [RW-1:0]       peak_next;
    logic                done_reg;
    logic [RW-1:0]       room_reg;
    logic                fail_reg;
    logic [RW+FW-1:0]    room_ext;
    logic [RW+FW-1:0]    peak_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= lfra_pkg::req_kind_t'(req_type);
        end
    end

    lfra_entry_store #(
        .CUSTOMERS (CUSTOMERS),
        .RW        (RW)
    ) u_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_cust (customer),
        .wr_en   (v_reg),
        .wr_data (wr_data),
        .rd_data (entry)
    );

    lfra_room_map #(
        .ROOMS (ROOMS),
        .RW    (RW)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (map_cmd),
        .give_room (entry),
        .lowest    (lowest)
    );

    always_comb
    begin
        map_cmd   = '0;
        room_next = '0;
        fail_next = 1'b0;
        wr_data   = '0;
        peak_next = peak_reg;
        case (kind_reg)
            lfra_pkg::REQ_ARRIVE:
            begin
                map_cmd.take = v_reg;
                room_next    = lowest;
                fail_next    = (lowest == '0);
                wr_data      = lowest;
                if (v_reg && (lowest > peak_reg))
                begin
                    peak_next = lowest;
                end
            end
            lfra_pkg::REQ_DEPART:
            begin
                map_cmd.give = v_reg;
                room_next    = entry;
            end
            default:
            begin
                room_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            peak_reg <= peak_next;
            done_reg <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_reg)
        begin
            room_reg <= room_next;
            fail_reg <= fail_next;
        end
    end

    assign room_ext  = {{FW{1'b0}}, room_reg};
    assign peak_ext  = {{FW{1'b0}}, peak_reg};
    assign done      = done_reg;
    assign room      = room_ext[FW-1:0];
    assign peak_room = peak_ext[FW-1:0];
    assign no_room   = fail_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted transaction produced no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |=> done_reg)
        else $error("result strobe missing after event stage");

    a_fail_no_room: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && fail_reg) |-> (room_reg == '0))
        else $error("failed arrival reported a room");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |=> (peak_reg >= $past(peak_reg)))
        else $error("peak room decreased");

    a_room_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !fail_reg && (kind_reg == lfra_pkg::REQ_ARRIVE) && !v_reg)
            |-> (room_reg <= peak_reg))
        else $error("assigned room above peak");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lowest_free_room_allocator: directed and random arrival and
// departure transactions, checked against a room-map predictor kept in this file.
// Depends on lfra_pkg and the allocator RTL.
module testbench;

    localparam int ROOMS         = 256;
    localparam int CUSTOMERS     = 1024;
    localparam int RANDOM_VISITS = 1600;
    localparam int QUIET_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 8;
    localparam int ROOM_W        = lfra_pkg::ROOM_FIELD_W;
    localparam int CUST_W        = lfra_pkg::CUST_FIELD_W;

    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [ROOM_W-1:0] peak;
        logic              full;
    } desk_reply_t;

    typedef struct {
        lfra_pkg::req_kind_t kind;
        int                  who;
        int                  idle_pct;
        bit                  settle_first;
    } visit_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              req_type = 1'b0;
    logic [CUST_W-1:0] customer = '0;
    logic              busy;
    logic              done;
    logic [ROOM_W-1:0] room;
    logic [ROOM_W-1:0] peak_room;
    logic              no_room;

    // Predictor state.
    bit              vacant [ROOMS];
    bit [ROOM_W-1:0] guest_room [CUSTOMERS];
    bit [ROOM_W-1:0] peak_taken;

    // Bookkeeping used only to shape the stimulus.
    bit ever_arrived [CUSTOMERS];
    bit holding [CUSTOMERS];
    int holders [$];
    int occupied;

    visit_t      visits [$];
    desk_reply_t owed_replies [$];
    desk_reply_t next_owed;
    int          mismatches;
    int          quiet_cycles;

    lowest_free_room_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .customer  (customer),
        .done      (done),
        .room      (room),
        .peak_room (peak_room),
        .no_room   (no_room)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic desk_reply_t check_in_or_out(lfra_pkg::req_kind_t kind, int who);
        desk_reply_t reply;
        int          r;
        reply = '0;
        r = 0;
        if (kind == lfra_pkg::REQ_ARRIVE)
        begin
            for (int i = ROOMS - 1; i >= 0; i--)
            begin
                if (vacant[i])
                    r = i + 1;
            end
            if (r == 0)
                reply.full = 1'b1;
            else
            begin
                vacant[r - 1] = 1'b0;
                if (r > int'(peak_taken))
                    peak_taken = ROOM_W'(r);
            end
            guest_room[who] = ROOM_W'(r);
        end
        else
        begin
            r = int'(guest_room[who]);
            if (r >= 1 && r <= ROOMS)
                vacant[r - 1] = 1'b1;
            else
                r = 0;
            guest_room[who] = '0;
        end
        reply.room = ROOM_W'(r);
        reply.peak = peak_taken;
        return reply;
    endfunction

    function automatic void check_field(string what, logic [ROOM_W-1:0] want,
                                        logic [ROOM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic drop_holder(int who);
        holding[who] = 1'b0;
        for (int i = 0; i < holders.size(); i++)
        begin
            if (holders[i] == who)
            begin
                holders.delete(i);
                break;
            end
        end
    endtask

    task automatic add_visit(lfra_pkg::req_kind_t kind, int who, int idle_pct,
                             bit settle_first);
        visit_t v;
        v.kind = kind;
        v.who = who;
        v.idle_pct = idle_pct;
        v.settle_first = settle_first;
        visits.insert(visits.size(), v);
        if (kind == lfra_pkg::REQ_ARRIVE)
        begin
            ever_arrived[who] = 1'b1;
            if (occupied < ROOMS)
            begin
                occupied++;
                if (!holding[who])
                begin
                    holding[who] = 1'b1;
                    holders.insert(holders.size(), who);
                end
            end
            else if (holding[who])
                drop_holder(who);
        end
        else if (holding[who])
        begin
            occupied--;
            drop_holder(who);
        end
    endtask

    // Driver: the transaction on the ports is taken at an edge with start high and busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= lfra_pkg::REQ_ARRIVE;
            customer <= '0;
        end
        else
        begin
            if (start && !busy)
                owed_replies.insert(owed_replies.size(),
                    check_in_or_out(lfra_pkg::req_kind_t'(req_type), int'(customer)));
            if (!start || !busy)
            begin
                if (visits.size() == 0
                    || (visits[0].settle_first && owed_replies.size() != 0)
                    || $urandom_range(0, 99) < visits[0].idle_pct)
                    start <= 1'b0;
                else
                begin
                    start <= 1'b1;
                    req_type <= visits[0].kind;
                    customer <= CUST_W'(visits[0].who);
                    void'(visits.pop_front());
                end
            end
        end
    end

    // Monitor: a result is valid for the one cycle that done is high.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (owed_replies.size() == 0)
            begin
                $display("%0t: unexpected result, room %0d peak_room %0d no_room %0b",
                         $time, room, peak_room, no_room);
                mismatches++;
            end
            else
            begin
                next_owed = owed_replies.pop_front();
                check_field("room", next_owed.room, room);
                check_field("peak_room", next_owed.peak, peak_room);
                check_field("no_room", ROOM_W'(next_owed.full), ROOM_W'(no_room));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("lowest_free_room_allocator test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int                  arrive_bias [8];
        int                  n;
        int                  who;
        int                  cand;
        int                  idle;
        int                  tries;
        lfra_pkg::req_kind_t kind;

        arrive_bias = '{95, 90, 30, 10, 60, 97, 40, 10};
        foreach (vacant[i])
            vacant[i] = 1'b1;
        peak_taken = '0;
        mismatches = 0;
        occupied = 0;

        // Reuse of the lowest freed room, repeated departures, a guest arriving again while
        // holding a room (the old room stays taken) and alternating customer bit patterns.
        add_visit(lfra_pkg::REQ_ARRIVE, 0, 7, 1'b0);
        add_visit(lfra_pkg::REQ_ARRIVE, 1023, 7, 1'b0);
        add_visit(lfra_pkg::REQ_ARRIVE, 512, 7, 1'b0);
        add_visit(lfra_pkg::REQ_ARRIVE, 341, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 1023, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 1023, 7, 1'b0);
        add_visit(lfra_pkg::REQ_ARRIVE, 341, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 341, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 341, 7, 1'b0);
        add_visit(lfra_pkg::REQ_ARRIVE, 682, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 0, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 512, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 682, 7, 1'b0);
        add_visit(lfra_pkg::REQ_ARRIVE, 1, 7, 1'b0);
        add_visit(lfra_pkg::REQ_DEPART, 1, 7, 1'b0);

        // Random traffic in batches whose arrival share drives the hotel from empty to full
        // and back, so failed arrivals and the top room are both reached.
        for (n = 0; n < RANDOM_VISITS; n++)
        begin
            idle = (n < 540) ? 7 : (n < 1080) ? 71 : 0;
            who = -1;
            if ($urandom_range(0, 99) < arrive_bias[n / 200])
            begin
                kind = lfra_pkg::REQ_ARRIVE;
                if ($urandom_range(0, 99) < 4 && holders.size() > 0)
                    who = holders[$urandom_range(0, holders.size() - 1)];
                else
                begin
                    who = $urandom_range(0, CUSTOMERS - 1);
                    while (holding[who])
                        who = $urandom_range(0, CUSTOMERS - 1);
                end
            end
            else
            begin
                kind = lfra_pkg::REQ_DEPART;
                if ($urandom_range(0, 99) < 10 || holders.size() == 0)
                begin
                    for (tries = 0; tries < 40 && who < 0; tries++)
                    begin
                        cand = $urandom_range(0, CUSTOMERS - 1);
                        if (ever_arrived[cand] && !holding[cand])
                            who = cand;
                    end
                end
                if (who < 0 && holders.size() > 0)
                    who = holders[$urandom_range(0, holders.size() - 1)];
                // Customer 0 has arrived already, so its departure is always legal.
                if (who < 0)
                    who = 0;
            end
            add_visit(kind, who, idle, n == 0 || n == 540 || n == 1080);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (visits.size() != 0 || start || owed_replies.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("lowest_free_room_allocator test passed");
        else
            $display("lowest_free_room_allocator test failed");
        $finish;
    end

endmodule

>>> lowest_free_room_allocator.f
sv/lfra_pkg.sv
sv/lfra_room_map.sv
sv/lfra_entry_store.sv
sv/lowest_free_room_allocator.sv
dv/testbench.sv
